>>> rtl/core/poly_voice_allocator_top_macros.svh
// assertion helpers shared by the allocator modules
`ifndef POLY_VOICE_ALLOCATOR_TOP_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define PVA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk outside reset
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pva_pkg.sv
`default_nettype none

package pva_pkg;

    localparam logic [1:0] OP_NOTE_ON    = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF   = 2'd1;
    localparam logic [1:0] OP_ENV_STATUS = 2'd2;

    localparam logic [6:0]  NOTE_RESET = 7'd57;
    localparam logic [31:0] AGE_MAX    = 32'hFFFF_FFFF;
    localparam logic [3:0]  COUNT_MAX  = 4'd15;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [2:0] voice_sel;
        logic       env_idle;
    } pva_in_t;

    typedef struct packed {
        logic [2:0] voice_index;
        logic       hit;
        logic       stolen;
        logic [3:0] active_voices;
    } pva_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } pva_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } pva_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/poly_voice_allocator_top.sv
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  in_item   (pva_in_t)
// out      out  out_valid / out_stall out_item (pva_out_t)
// cfg      in   cfg_valid / cfg_ready cfg_data (poly_enabled)
//
// every item is latched, then scanned one voice at a time through the shared
// compare unit, and then committed
// a full output register holds the commit until out_stall drops
// a new item is accepted while the previous result still waits at the output
// reset is asynchronous, active low, and clears all voice state at once
`default_nettype none

module poly_voice_allocator_top
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = 8
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire pva_in_t in_item,
    output logic         out_valid,
    input  wire logic    out_stall,
    output pva_out_t     out_item,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire logic    cfg_data
);

    pva_cmd_t  cmd;
    pva_stat_t stat;

    assign cfg_ready = 1'b1;

    pva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pva_dp #(
        .NUM_VOICES (NUM_VOICES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

>>> rtl/core/pva_ctrl.sv
`default_nettype none

`include "poly_voice_allocator_top_macros.svh"

module pva_ctrl
    import pva_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire pva_stat_t stat,
    output pva_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // wait for room in the output register
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PVA_ASSERT_NOW(a_commit_has_room, cmd.commit, stat.out_free, "commit without output room")
    `PVA_ASSERT_NEXT(a_load_starts_scan, cmd.load, state_reg == S_SCAN, "load did not start scan")

endmodule

`default_nettype wire

>>> rtl/core/pva_dp.sv
`default_nettype none

`include "poly_voice_allocator_top_macros.svh"

module pva_dp
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pva_cmd_t cmd,
    output pva_stat_t     stat,
    input  wire pva_in_t  in_item,
    input  wire logic     cfg_we,
    input  wire logic     cfg_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output pva_out_t      out_item
);

    localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int PW = $clog2(NUM_VOICES + 1);
    localparam logic [IW-1:0] LAST = IW'(NUM_VOICES - 1);

    // per-voice state
    logic [NUM_VOICES-1:0] active_reg;
    logic [NUM_VOICES-1:0] env_reg;
    logic [6:0]            note_reg [NUM_VOICES];
    logic [31:0]           age_reg  [NUM_VOICES];

    logic          poly_reg;
    logic [31:0]   age_ctr_reg;
    logic [3:0]    count_reg;
    logic [PW-1:0] pop_reg;
    pva_in_t       item_reg;

    // scan state
    logic [IW-1:0] scan_reg;
    logic          fnd_idle_reg;
    logic          fnd_free_reg;
    logic          fnd_match_reg;
    logic [IW-1:0] idle_idx_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] match_idx_reg;
    logic [IW-1:0] old_idx_reg;
    logic [31:0]   best_reg;

    logic     out_valid_reg;
    pva_out_t out_item_reg;

    // commit decode
    logic          is_poly;
    logic [IW-1:0] tgt;
    logic          set_act;
    logic          clr_act;
    logic          wr_age;
    logic          wr_env;
    logic          recount;
    logic [PW-1:0] pop_next;
    logic [3:0]    cnt_next;
    pva_out_t      res;

    logic cur_act;
    logic cur_env;

    assign cur_act        = active_reg[scan_reg];
    assign cur_env        = env_reg[scan_reg];
    assign stat.scan_last = (scan_reg == LAST);
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign out_item       = out_item_reg;
    assign is_poly        = poly_reg;

    always_comb
    begin
        tgt      = '0;
        set_act  = 1'b0;
        clr_act  = 1'b0;
        wr_age   = 1'b0;
        wr_env   = 1'b0;
        recount  = 1'b0;
        pop_next = pop_reg;
        cnt_next = count_reg;
        res      = '0;
        unique case (item_reg.op)
            OP_NOTE_ON:
            begin
                set_act = 1'b1;
                res.hit = 1'b1;
                if (!is_poly)
                begin
                    if (!active_reg[0])
                    begin
                        pop_next = pop_reg + PW'(1);
                    end
                    cnt_next = 4'd1;
                end
                else
                begin
                    // idle-envelope free voice, then any free voice, then oldest
                    priority if (fnd_idle_reg)
                    begin
                        tgt = idle_idx_reg;
                    end
                    else if (fnd_free_reg)
                    begin
                        tgt = free_idx_reg;
                    end
                    else
                    begin
                        tgt = old_idx_reg;
                    end
                    if (fnd_free_reg)
                    begin
                        pop_next = pop_reg + PW'(1);
                    end
                    wr_age     = 1'b1;
                    recount    = 1'b1;
                    res.stolen = !fnd_free_reg;
                end
            end
            OP_NOTE_OFF:
            begin
                if (!is_poly)
                begin
                    if (active_reg[0] && note_reg[0] == item_reg.note)
                    begin
                        clr_act  = 1'b1;
                        res.hit  = 1'b1;
                        pop_next = pop_reg - PW'(1);
                    end
                end
                else
                begin
                    if (fnd_match_reg)
                    begin
                        tgt      = match_idx_reg;
                        clr_act  = 1'b1;
                        res.hit  = 1'b1;
                        pop_next = pop_reg - PW'(1);
                    end
                    recount = 1'b1;
                end
            end
            OP_ENV_STATUS:
            begin
                wr_env = (32'(item_reg.voice_sel) < NUM_VOICES);
            end
            default:
            begin
            end
        endcase
        if (recount)
        begin
            cnt_next = (32'(pop_next) > 32'(COUNT_MAX)) ? COUNT_MAX : 4'(pop_next);
        end
        res.voice_index   = 3'(tgt);
        res.active_voices = cnt_next;
    end

    // control and per-voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= 1'b0;
            active_reg    <= '0;
            env_reg       <= '1;
            age_ctr_reg   <= 32'd1;
            count_reg     <= '0;
            pop_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                note_reg[i] <= NOTE_RESET;
                age_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                poly_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                count_reg <= cnt_next;
                pop_reg   <= pop_next;
                if (wr_age)
                begin
                    age_ctr_reg <= age_ctr_reg + 32'd1;
                end
                for (int i = 0; i < NUM_VOICES; i++)
                begin
                    if (tgt == IW'(i))
                    begin
                        if (set_act)
                        begin
                            active_reg[i] <= 1'b1;
                            note_reg[i]   <= item_reg.note;
                        end
                        if (clr_act)
                        begin
                            active_reg[i] <= 1'b0;
                        end
                        if (wr_age)
                        begin
                            age_reg[i] <= age_ctr_reg;
                        end
                    end
                    if (wr_env && 32'(item_reg.voice_sel) == i)
                    begin
                        env_reg[i] <= item_reg.env_idle;
                    end
                end
            end
        end
    end

    // item latch, scan and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg      <= in_item;
            scan_reg      <= '0;
            fnd_idle_reg  <= 1'b0;
            fnd_free_reg  <= 1'b0;
            fnd_match_reg <= 1'b0;
            idle_idx_reg  <= '0;
            free_idx_reg  <= '0;
            match_idx_reg <= '0;
            old_idx_reg   <= '0;
            best_reg      <= AGE_MAX;
        end
        else if (cmd.step)
        begin
            if (!stat.scan_last)
            begin
                scan_reg <= scan_reg + IW'(1);
            end
            if (!fnd_idle_reg && !cur_act && cur_env)
            begin
                fnd_idle_reg <= 1'b1;
                idle_idx_reg <= scan_reg;
            end
            if (!fnd_free_reg && !cur_act)
            begin
                fnd_free_reg <= 1'b1;
                free_idx_reg <= scan_reg;
            end
            if (!fnd_match_reg && cur_act && note_reg[scan_reg] == item_reg.note)
            begin
                fnd_match_reg <= 1'b1;
                match_idx_reg <= scan_reg;
            end
            // strict compare keeps the lowest index on equal ages
            if (age_reg[scan_reg] < best_reg)
            begin
                best_reg    <= age_reg[scan_reg];
                old_idx_reg <= scan_reg;
            end
        end
        if (cmd.commit)
        begin
            out_item_reg <= res;
        end
    end

    `PVA_ASSERT_NOW(a_pop_range, 1'b1, 32'(pop_reg) <= NUM_VOICES, "active population out of range")
    `PVA_ASSERT_NEXT(a_commit_shows_item, cmd.commit, out_valid_reg, "committed item not shown")

endmodule

`default_nettype wire

>>> sim/poly_voice_allocator_top_tb.sv
`timescale 1ns / 1ps

module poly_voice_allocator_top_tb;
    import pva_pkg::*;

    localparam int VOICES = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * (VOICES + 2);
    localparam int STALL_LIMIT = 2000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    pva_in_t  in_item = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    pva_out_t out_item;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data = 1'b0;

    poly_voice_allocator_top #(
        .NUM_VOICES(VOICES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // allocator state as the testbench sees it
    logic        poly_mode = 1'b0;
    logic        voice_on[VOICES];
    logic [6:0]  held_note[VOICES];
    logic [6:0]  held_vel[VOICES];
    logic [31:0] stamp[VOICES];
    logic        env_quiet[VOICES];
    logic [31:0] next_stamp = 32'd1;
    logic [3:0]  live_count = 4'd0;

    pva_in_t  note_events[$];
    pva_out_t predicted_voices[$];
    logic [6:0] sounding[$];

    int items_queued = 0;
    int results_seen = 0;
    int mode_writes = 0;
    int steals_seen = 0;
    int releases_seen = 0;
    int err_count = 0;
    int dead_cycles = 0;
    bit in_taken = 1'b0;
    bit tail_quiet = 1'b0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    int in_gap = 0;
    int out_hold = 0;

    initial begin
        for (int v = 0; v < VOICES; v++)
        begin
            voice_on[v] = 1'b0;
            held_note[v] = NOTE_RESET;
            held_vel[v] = 7'd0;
            stamp[v] = 32'd0;
            env_quiet[v] = 1'b1;
        end
    end

    task automatic flag_error(string msg);
        if (err_count < 50)
            $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic [3:0] count_live();
        int n;
        n = 0;
        for (int v = 0; v < VOICES; v++)
            if (voice_on[v])
                n++;
        return (n > 15) ? COUNT_MAX : n[3:0];
    endfunction

    function automatic pva_out_t allocate_voice(pva_in_t ev);
        pva_out_t r;
        int pick;
        bit found;
        logic [31:0] best;
        r = '0;
        pick = 0;
        found = 1'b0;
        case (ev.op)
            OP_NOTE_ON:
            begin
                if (!poly_mode)
                begin
                    held_note[0] = ev.note;
                    held_vel[0] = ev.velocity;
                    voice_on[0] = 1'b1;
                    live_count = 4'd1;
                end
                else
                begin
                    for (int v = 0; v < VOICES; v++)
                        if (!found && !voice_on[v] && env_quiet[v])
                        begin
                            pick = v;
                            found = 1'b1;
                        end
                    for (int v = 0; v < VOICES; v++)
                        if (!found && !voice_on[v])
                        begin
                            pick = v;
                            found = 1'b1;
                        end
                    if (!found)
                    begin
                        // oldest stamp wins, lowest index on ties
                        best = AGE_MAX;
                        for (int v = 0; v < VOICES; v++)
                            if (stamp[v] < best)
                            begin
                                best = stamp[v];
                                pick = v;
                            end
                        r.stolen = 1'b1;
                    end
                    stamp[pick] = next_stamp;
                    next_stamp = next_stamp + 32'd1;
                    held_note[pick] = ev.note;
                    held_vel[pick] = ev.velocity;
                    voice_on[pick] = 1'b1;
                    live_count = count_live();
                end
                r.hit = 1'b1;
            end
            OP_NOTE_OFF:
            begin
                if (!poly_mode)
                begin
                    // voice 0 only, count left alone
                    if (held_note[0] == ev.note)
                    begin
                        r.hit = voice_on[0];
                        voice_on[0] = 1'b0;
                    end
                end
                else
                begin
                    for (int v = 0; v < VOICES; v++)
                        if (!found && voice_on[v] && held_note[v] == ev.note)
                        begin
                            voice_on[v] = 1'b0;
                            pick = v;
                            r.hit = 1'b1;
                            found = 1'b1;
                        end
                    live_count = count_live();
                end
            end
            OP_ENV_STATUS:
                env_quiet[ev.voice_sel] = ev.env_idle;
            default:
                ;
        endcase
        r.voice_index = r.hit ? pick[2:0] : 3'd0;
        r.active_voices = live_count;
        return r;
    endfunction

    task automatic check_voice(pva_out_t got);
        pva_out_t want;
        if (predicted_voices.size() == 0)
        begin
            flag_error($sformatf("unexpected result %p", got));
            return;
        end
        want = predicted_voices.pop_front();
        if (got.voice_index !== want.voice_index)
            flag_error($sformatf("voice_index got %0d want %0d",
                                 got.voice_index, want.voice_index));
        if (got.hit !== want.hit)
            flag_error($sformatf("hit got %b want %b", got.hit, want.hit));
        if (got.stolen !== want.stolen)
            flag_error($sformatf("stolen got %b want %b", got.stolen, want.stolen));
        if (got.active_voices !== want.active_voices)
            flag_error($sformatf("active_voices got %0d want %0d",
                                 got.active_voices, want.active_voices));
    endtask

    // monitor: results first, so an item accepted at the same edge cannot cover a stray result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                check_voice(out_item);
                if (out_item.stolen)
                    steals_seen++;
                results_seen++;
            end
            if (in_taken)
            begin
                if (in_item.op == OP_NOTE_OFF)
                    releases_seen++;
                predicted_voices.push_back(allocate_voice(in_item));
            end
            if (cfg_valid && cfg_ready)
            begin
                poly_mode = cfg_data;
                mode_writes++;
            end
            if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
    end

    // item driver
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            in_calm = !in_calm;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            ;
        else
        begin
            if (in_gap == 0 && !tail_quiet && !in_calm && $urandom_range(0, 7) == 0)
                in_gap = $urandom_range(1, 13);
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (note_events.size() > 0)
            begin
                in_item <= note_events.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            out_calm = !out_calm;
        if (out_hold == 0 && !tail_quiet && !out_calm && $urandom_range(0, 7) == 0)
            out_hold = $urandom_range(1, 13);
        if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial begin
        @(posedge rst_n);
        while (dead_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    task automatic push_event(logic [1:0] op, logic [6:0] note, logic [6:0] vel,
                              logic [2:0] sel, logic idle);
        pva_in_t ev;
        ev.op = op;
        ev.note = note;
        ev.velocity = vel;
        ev.voice_sel = sel;
        ev.env_idle = idle;
        note_events.push_back(ev);
        items_queued++;
    endtask

    task automatic write_mode(logic poly);
        int seen;
        seen = mode_writes;
        cfg_data <= poly;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (mode_writes == seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly note-on / note-off pairs over a small pool of notes, plus noise
    task automatic random_events(int n);
        int made;
        int roll;
        int k;
        logic [6:0] nt;
        made = 0;
        while (made < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                nt = $urandom_range(0, 1) ? 7'($urandom_range(60, 67))
                                          : 7'($urandom_range(0, 127));
                push_event(OP_NOTE_ON, nt, 7'($urandom), 3'($urandom), 1'($urandom));
                sounding.push_back(nt);
                if (sounding.size() > 12)
                    void'(sounding.pop_front());
                made++;
            end
            else if (roll < 82)
            begin
                if (roll < 75 && sounding.size() > 0)
                begin
                    k = $urandom_range(0, sounding.size() - 1);
                    nt = sounding[k];
                    sounding.delete(k);
                end
                else
                    nt = 7'($urandom);
                push_event(OP_NOTE_OFF, nt, 7'($urandom), 3'($urandom), 1'($urandom));
                made++;
            end
            else if (roll < 95)
            begin
                push_event(OP_ENV_STATUS, 7'($urandom), 7'($urandom),
                           3'($urandom_range(0, VOICES - 1)), 1'($urandom));
                made++;
            end
            else
                push_event(OP_UNUSED, 7'($urandom), 7'($urandom), 3'($urandom),
                           1'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // mono: reset note held by an idle voice, extremes, misses, status, unused op
        write_mode(1'b0);
        push_event(OP_NOTE_OFF, NOTE_RESET, 7'd0, 3'd0, 1'b0);
        push_event(OP_NOTE_ON, 7'd0, 7'd0, 3'd0, 1'b0);
        push_event(OP_NOTE_ON, 7'd127, 7'd127, 3'd7, 1'b1);
        push_event(OP_NOTE_OFF, 7'd127, 7'd0, 3'd0, 1'b0);
        push_event(OP_NOTE_OFF, 7'd127, 7'd0, 3'd0, 1'b0);
        push_event(OP_NOTE_OFF, 7'd3, 7'd0, 3'd0, 1'b0);
        push_event(OP_ENV_STATUS, 7'd0, 7'd0, 3'd7, 1'b0);
        push_event(OP_ENV_STATUS, 7'd127, 7'd127, 3'd7, 1'b1);
        push_event(OP_UNUSED, 7'd127, 7'd127, 3'd7, 1'b1);
        wait_drained();

        // poly: skip a busy envelope, fill every voice, steal the oldest, miss and release
        write_mode(1'b1);
        push_event(OP_ENV_STATUS, 7'd0, 7'd0, 3'd0, 1'b0);
        for (int i = 0; i < VOICES + 1; i++)
            push_event(OP_NOTE_ON, 7'(10 + i), 7'($urandom), 3'd0, 1'b0);
        push_event(OP_NOTE_OFF, 7'd100, 7'd0, 3'd0, 1'b0);
        push_event(OP_NOTE_OFF, 7'd12, 7'd0, 3'd0, 1'b0);
        wait_drained();

        // mono with other voices still on: count forced to one and kept on release
        write_mode(1'b0);
        push_event(OP_NOTE_ON, 7'd64, 7'd90, 3'd0, 1'b0);
        push_event(OP_NOTE_OFF, 7'd64, 7'd0, 3'd0, 1'b0);
        wait_drained();

        write_mode(1'b1);
        random_events(150);
        wait_drained();
        write_mode(1'b0);
        random_events(80);
        wait_drained();
        write_mode(1'b1);
        random_events(120);
        wait_drained();
        tail_quiet = 1'b1;
        random_events(60);
        wait_drained();

        $display("checked %0d allocator results over %0d mode writes", results_seen,
                 mode_writes);
        $display("%0d note-off items, %0d voices stolen by age", releases_seen, steals_seen);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> poly_voice_allocator_top.f
+incdir+rtl/core
rtl/core/pva_pkg.sv
rtl/core/pva_ctrl.sv
rtl/core/pva_dp.sv
rtl/core/poly_voice_allocator_top.sv
sim/poly_voice_allocator_top_tb.sv
